// ----- hdl/fdt_pkg.sv -----
`timescale 1ns / 1ps

package fdt_pkg;

  // fixed field and datapath widths
  localparam int SAMPLE_W = 8;
  localparam int OUT_W    = 8;
  localparam int COEF_W   = 12;
  localparam int PROD_W   = COEF_W + SAMPLE_W;
  // worst case |sum| over the whole table stays below 2**22
  localparam int ACC_W    = 24;
  localparam int CNT_W    = 4;
  localparam int SLOT_W   = 4;
  localparam int TAP_W    = 4;
  localparam int COEF_DIM = 10;

  // coefficient table, indexed [phase][tap]
  localparam logic signed [COEF_W-1:0] COEF_TABLE [COEF_DIM][COEF_DIM] = '{
    '{12'sd1,  -12'sd3,  12'sd11,  -12'sd28,  12'sd78,   12'sd1627, -12'sd69,  12'sd26,  -12'sd10, 12'sd3},
    '{12'sd3,  -12'sd11, 12'sd35,  -12'sd91,  12'sd259,  12'sd1571, -12'sd181, 12'sd69,  -12'sd26, 12'sd7},
    '{12'sd6,  -12'sd20, 12'sd61,  -12'sd156, 12'sd465,  12'sd1462, -12'sd253, 12'sd98,  -12'sd36, 12'sd10},
    '{12'sd8,  -12'sd28, 12'sd85,  -12'sd216, 12'sd685,  12'sd1309, -12'sd288, 12'sd113, -12'sd41, 12'sd12},
    '{12'sd10, -12'sd36, 12'sd104, -12'sd263, 12'sd908,  12'sd1120, -12'sd290, 12'sd114, -12'sd40, 12'sd11},
    '{12'sd11, -12'sd40, 12'sd114, -12'sd290, 12'sd1120, 12'sd908,  -12'sd263, 12'sd104, -12'sd36, 12'sd10},
    '{12'sd12, -12'sd41, 12'sd113, -12'sd288, 12'sd1309, 12'sd685,  -12'sd216, 12'sd85,  -12'sd28, 12'sd8},
    '{12'sd10, -12'sd36, 12'sd98,  -12'sd253, 12'sd1462, 12'sd465,  -12'sd156, 12'sd61,  -12'sd20, 12'sd6},
    '{12'sd7,  -12'sd26, 12'sd69,  -12'sd181, 12'sd1571, 12'sd259,  -12'sd91,  12'sd35,  -12'sd11, 12'sd3},
    '{12'sd3,  -12'sd10, 12'sd26,  -12'sd69,  12'sd1627, 12'sd78,   -12'sd28,  12'sd11,  -12'sd3,  12'sd1}
  };

  // sequencer state
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  // one accumulator update issued by the sequencer
  typedef struct packed {
    logic              issue;
    logic              load;
    logic              first;
    logic              fire;
    logic [SLOT_W-1:0] slot;
    logic [TAP_W-1:0]  tap;
    logic [CNT_W-1:0]  phase;
  } mac_ctl_t;

  // finished sum handed to the output stage
  typedef struct packed {
    logic                    vld;
    logic signed [ACC_W-1:0] sum;
  } res_t;

  // coefficient lookup, zero outside the table
  function automatic logic signed [COEF_W-1:0] coef_f(input logic [CNT_W-1:0] phase,
                                                      input logic [TAP_W-1:0] tap);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if ((phase < CNT_W'(COEF_DIM)) && (tap < TAP_W'(COEF_DIM))) begin
      c = COEF_TABLE[phase][tap];
    end
    return c;
  endfunction

endpackage

// ----- hdl/fdt_acc_mem.sv -----
`timescale 1ns / 1ps

module fdt_acc_mem #(
  parameter int DEPTH = 10,
  parameter int AW    = 4,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] acc_mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      acc_mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= acc_mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/fdt_seq.sv -----
`timescale 1ns / 1ps

module fdt_seq #(
  parameter int DECIMATION     = 10,
  parameter int TAPS_PER_PHASE = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_valid,
  output logic              in_stall,
  output fdt_pkg::mac_ctl_t ctl
);

  import fdt_pkg::*;

  localparam int KW = (TAPS_PER_PHASE > 1) ? $clog2(TAPS_PER_PHASE) : 1;

  seq_state_t       state_r, state_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [KW-1:0]    slot_r, slot_nxt;
  logic [KW-1:0]    base_r, base_nxt;
  logic [CNT_W-1:0] phase_r, phase_nxt;
  logic [CNT_W-1:0] cur_phase_r, cur_phase_nxt;
  logic             first_r, first_nxt;
  logic [CNT_W-1:0] cnt_inc;
  logic             fire_now;
  logic             accept;
  logic             last_issue;
  logic [KW-1:0]    base_inc;

  function automatic logic [KW-1:0] slot_inc_f(input logic [KW-1:0] s);
    logic [KW-1:0] n;
    n = (s == KW'(TAPS_PER_PHASE - 1)) ? '0 : s + KW'(1);
    return n;
  endfunction

  // phase count and firing decision for the next sample
  assign cnt_inc  = phase_r + CNT_W'(1);
  assign fire_now = ({1'b0, cnt_inc} >= (CNT_W + 1)'(DECIMATION));
  assign base_inc = slot_inc_f(base_r);

  // input handshake: one sample per pass over the taps
  assign in_stall = (state_r == ST_RUN) || (fire_now && out_valid);
  assign accept   = in_valid && !in_stall;

  assign last_issue = (state_r == ST_IDLE) ? (accept && (TAPS_PER_PHASE == 1))
                                           : (k_r == KW'(TAPS_PER_PHASE - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (TAPS_PER_PHASE > 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_issue) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // counters and pointers
  always_comb begin
    k_nxt         = k_r;
    slot_nxt      = slot_r;
    base_nxt      = base_r;
    phase_nxt     = phase_r;
    cur_phase_nxt = cur_phase_r;
    first_nxt     = first_r && !last_issue;
    if (accept) begin
      k_nxt         = KW'(1);
      slot_nxt      = base_inc;
      cur_phase_nxt = phase_r;
      phase_nxt     = fire_now ? '0 : cnt_inc;
      base_nxt      = fire_now ? base_inc : base_r;
    end else if (state_r == ST_RUN) begin
      k_nxt    = k_r + KW'(1);
      slot_nxt = slot_inc_f(slot_r);
    end
  end

  // update issued to the accumulator datapath
  always_comb begin
    ctl       = '0;
    ctl.load  = accept;
    ctl.first = first_r;
    case (state_r)
      ST_IDLE: begin
        ctl.issue = accept;
        ctl.fire  = fire_now;
        ctl.slot  = SLOT_W'(base_r);
        ctl.tap   = TAP_W'(TAPS_PER_PHASE - 1);
        ctl.phase = phase_r;
      end
      ST_RUN: begin
        ctl.issue = 1'b1;
        ctl.slot  = SLOT_W'(slot_r);
        ctl.tap   = TAP_W'(TAPS_PER_PHASE - 1) - TAP_W'(k_r);
        ctl.phase = cur_phase_r;
      end
      default: ctl.issue = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      slot_r      <= '0;
      base_r      <= '0;
      phase_r     <= '0;
      cur_phase_r <= '0;
      first_r     <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      slot_r      <= slot_nxt;
      base_r      <= base_nxt;
      phase_r     <= phase_nxt;
      cur_phase_r <= cur_phase_nxt;
      first_r     <= first_nxt;
    end
  end

  // no sample may enter while a pass is running
  a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> in_stall)
    else $error("sample accepted during a tap pass");

  // phase count stays inside one decimation frame
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, phase_r} < (CNT_W + 1)'(DECIMATION)))
    else $error("phase count out of range");

  // a firing sample never enters while a result still waits
  a_fire_room: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && fire_now) |-> !out_valid)
    else $error("firing sample accepted with output full");

endmodule

// ----- hdl/fdt_mac.sv -----
`timescale 1ns / 1ps

module fdt_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fdt_pkg::mac_ctl_t             ctl,
  input  logic signed [fdt_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [fdt_pkg::ACC_W-1:0]     rd_data,
  output logic                          wr_en,
  output logic [fdt_pkg::SLOT_W-1:0]    wr_slot,
  output logic [fdt_pkg::ACC_W-1:0]     wr_data,
  output fdt_pkg::res_t                 res
);

  import fdt_pkg::*;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] sample_cur;
  logic signed [COEF_W-1:0]   coef_w;
  logic signed [PROD_W-1:0]   prod_nxt, prod_r;
  logic                       s1_vld_r;
  logic                       s1_first_r;
  logic                       s1_fire_r;
  logic [SLOT_W-1:0]          s1_slot_r;
  logic                       fwd_nxt, fwd_r;
  logic [ACC_W-1:0]           fwd_data_r;
  logic signed [ACC_W-1:0]    operand;
  logic signed [ACC_W-1:0]    sum;

  // sample held for the rest of the pass
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sample_r <= in_sample;
    end
  end

  // issue stage: product alongside the memory read
  assign sample_cur = ctl.load ? in_sample : sample_r;
  assign coef_w     = coef_f(ctl.phase, ctl.tap);
  assign prod_nxt   = coef_w * sample_cur;

  // read and write of the same slot in one cycle
  assign fwd_nxt = ctl.issue && wr_en && (wr_slot == ctl.slot);

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    s1_first_r <= ctl.first;
    s1_fire_r  <= ctl.fire;
    s1_slot_r  <= ctl.slot;
    fwd_data_r <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else begin
      s1_vld_r <= ctl.issue;
      fwd_r    <= fwd_nxt;
    end
  end

  // accumulate stage: untouched slots read as zero on the first pass
  always_comb begin
    if (s1_first_r) begin
      operand = '0;
    end else if (fwd_r) begin
      operand = $signed(fwd_data_r);
    end else begin
      operand = $signed(rd_data);
    end
  end

  assign sum = operand + ACC_W'(prod_r);

  // a slot that completes an output restarts from zero
  assign wr_en   = s1_vld_r;
  assign wr_slot = s1_slot_r;
  assign wr_data = s1_fire_r ? '0 : sum;

  assign res.vld = s1_vld_r && s1_fire_r;
  assign res.sum = sum;

  // forwarding only ever covers a live update after the first pass
  a_fwd_live: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> (s1_vld_r && !s1_first_r))
    else $error("forwarded data without a live update");

endmodule

// ----- hdl/fdt_post.sv -----
`timescale 1ns / 1ps

module fdt_post #(
  parameter int SCALE_SHIFT = 14
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fdt_pkg::res_t                      res,
  input  logic                               round_en,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic signed [fdt_pkg::OUT_W-1:0]   out_filtered,
  output logic                               out_overflow
);

  import fdt_pkg::*;

  logic signed [ACC_W-1:0] q;
  logic signed [ACC_W:0]   r;
  logic                    rbit;
  logic                    ovf;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]        filtered_r;
  logic                    overflow_r;

  // arithmetic shift, optional round half up, wrap check
  assign q    = $signed(res.sum) >>> SCALE_SHIFT;
  assign rbit = round_en & res.sum[SCALE_SHIFT-1];
  assign r    = {q[ACC_W-1], q} + (ACC_W + 1)'(rbit);
  assign ovf  = !((&r[ACC_W:OUT_W-1]) || !(|r[ACC_W:OUT_W-1]));

  // output register, held while the receiver stalls
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (res.vld) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      filtered_r <= r[OUT_W-1:0];
      overflow_r <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = $signed(filtered_r);
  assign out_overflow = overflow_r;

endmodule

// ----- hdl/decimating_fir_by_ten_top.sv -----
`timescale 1ns / 1ps

// Decimating FIR filter: DECIMATION * TAPS_PER_PHASE taps, one output per
// DECIMATION input samples, coefficients scaled by 2**SCALE_SHIFT.
// Input channel: in_valid / in_stall carrying in_sample (signed 8 bit).
// Output channel: out_valid / out_stall carrying out_filtered (signed 8 bit)
// and out_overflow, set when the scaled sum wrapped.
// Config channel: cfg_valid / cfg_ready carrying cfg_data, the round enable
// (1 rounds half up, 0 truncates); cfg_ready is always high.
// Each sample updates one partial sum per cycle in a TAPS_PER_PHASE-entry
// accumulator memory (one read and one write port), one partial sum for
// each pending output.
// A result passes the accumulate stage register and the output register
// before out_valid, once the sample that completes it is accepted.
// Reset clears the phase count and the sample history (first pass reads the
// partial sums as zero) and sets round enable to 1; no clearing pass.
// While out_valid waits under out_stall, the sample that would complete the
// next output is stalled; other samples are still taken.
module decimating_fir_by_ten_top #(
  parameter int DECIMATION     = 10,
  parameter int TAPS_PER_PHASE = 10,
  parameter int SCALE_SHIFT    = 14
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [fdt_pkg::SAMPLE_W-1:0]    in_sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [fdt_pkg::OUT_W-1:0]       out_filtered,
  output logic                                   out_overflow,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic                                   cfg_data
);

  import fdt_pkg::*;

  localparam int AW = (TAPS_PER_PHASE > 1) ? $clog2(TAPS_PER_PHASE) : 1;

  mac_ctl_t         ctl;
  res_t             res;
  logic             wr_en;
  logic [SLOT_W-1:0] wr_slot;
  logic [ACC_W-1:0] wr_data;
  logic [ACC_W-1:0] rd_data;
  logic             round_en_r;

  // round enable register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_en_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      round_en_r <= cfg_data;
    end
  end

  // tap sequencer
  fdt_seq #(
    .DECIMATION     (DECIMATION),
    .TAPS_PER_PHASE (TAPS_PER_PHASE)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_valid (out_valid),
    .in_stall  (in_stall),
    .ctl       (ctl)
  );

  // partial sum memory
  fdt_acc_mem #(
    .DEPTH (TAPS_PER_PHASE),
    .AW    (AW),
    .DW    (ACC_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_slot[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (ctl.issue),
    .rd_addr (ctl.slot[AW-1:0]),
    .rd_data (rd_data)
  );

  // multiply-accumulate read-modify-write
  fdt_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_sample (in_sample),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_slot   (wr_slot),
    .wr_data   (wr_data),
    .res       (res)
  );

  // scaling, rounding and output register
  fdt_post #(
    .SCALE_SHIFT (SCALE_SHIFT)
  ) u_post (
    .clk          (clk),
    .rst_n        (rst_n),
    .res          (res),
    .round_en     (round_en_r),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_filtered (out_filtered),
    .out_overflow (out_overflow)
  );

  // every new result traces back to an accepted request, via the accumulate and output registers
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a completing request");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int DECIM       = 10;
  localparam int PHASE_TAPS  = 10;
  localparam int WINDOW_LEN  = DECIM * PHASE_TAPS;
  localparam int SHIFT       = 14;
  localparam int SETTLE      = 2 * PHASE_TAPS;
  localparam int TAIL        = 4 * PHASE_TAPS;
  localparam int STUCK_LIMIT = 2000;
  localparam int BACKLOG_AT  = 40;
  localparam int BACKLOG_LEN = 300;

  // filter weights, indexed [phase][tap], scaled by 2**SHIFT
  localparam int WEIGHT [10][10] = '{
    '{1,  -3,  11,  -28,  78,   1627, -69,  26,  -10, 3},
    '{3,  -11, 35,  -91,  259,  1571, -181, 69,  -26, 7},
    '{6,  -20, 61,  -156, 465,  1462, -253, 98,  -36, 10},
    '{8,  -28, 85,  -216, 685,  1309, -288, 113, -41, 12},
    '{10, -36, 104, -263, 908,  1120, -290, 114, -40, 11},
    '{11, -40, 114, -290, 1120, 908,  -263, 104, -36, 10},
    '{12, -41, 113, -288, 1309, 685,  -216, 85,  -28, 8},
    '{10, -36, 98,  -253, 1462, 465,  -156, 61,  -20, 6},
    '{7,  -26, 69,  -181, 1571, 259,  -91,  35,  -11, 3},
    '{3,  -10, 26,  -69,  1627, 78,   -28,  11,  -3,  1}
  };

  typedef logic signed [fdt_pkg::SAMPLE_W-1:0] sample_t;

  typedef enum logic {
    KIND_SAMPLE,
    KIND_SETUP
  } req_kind_t;

  // sample block shapes for the random part
  typedef enum logic [2:0] {
    SHAPE_NOISE,
    SHAPE_RAIL,
    SHAPE_HELD,
    SHAPE_QUIET,
    SHAPE_TOGGLE,
    SHAPE_PULSE
  } shape_t;

  typedef struct packed {
    req_kind_t  kind;
    sample_t    value;
    logic [3:0] gap;
  } request_t;

  typedef struct packed {
    logic signed [fdt_pkg::OUT_W-1:0] filtered;
    logic                             overflow;
  } decimated_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  sample_t in_sample = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  logic signed [fdt_pkg::OUT_W-1:0] out_filtered;
  logic    out_overflow;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic    cfg_data = 1'b0;

  // predictor state
  sample_t    history [WINDOW_LEN];
  logic [3:0] phase_cnt;
  logic       round_on;
  decimated_t decimated_q [$];
  decimated_t want;

  request_t request_plan [$];
  int       plan_len;
  int       items_taken;
  int       quiet_cnt;
  int       err_cnt = 0;
  int       stuck_cnt;

  // driver state
  request_t drv_req;
  logic     drv_loaded;
  int       drv_wait;
  logic     in_hold, cfg_hold, in_next, cfg_next;

  // receiver state
  int rx_hold;
  int rx_taken;
  int rx_draw;

  decimating_fir_by_ten_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_filtered (out_filtered),
    .out_overflow (out_overflow),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shift one sample in; on every tenth one work out the decimated output
  function automatic bit decimate_sample(input sample_t s, output decimated_t res);
    longint acc;
    longint scaled;
    acc = 0;
    res = '0;
    for (int k = 0; k < WINDOW_LEN - 1; k++) begin
      history[k] = history[k + 1];
    end
    history[WINDOW_LEN - 1] = s;
    phase_cnt = phase_cnt + 4'd1;
    if (phase_cnt < 4'(DECIM)) begin
      return 1'b0;
    end
    phase_cnt = '0;
    // oldest sample at offset 0; offset i*DECIM+j takes weight [j][i]
    for (int i = 0; i < PHASE_TAPS; i++) begin
      for (int j = 0; j < DECIM; j++) begin
        acc += longint'(WEIGHT[j][i]) * longint'(history[i * DECIM + j]);
      end
    end
    scaled = acc >>> SHIFT;
    if (round_on) begin
      scaled += longint'(acc[SHIFT - 1]);
    end
    res.filtered = scaled[fdt_pkg::OUT_W-1:0];
    res.overflow = (scaled < -128) || (scaled > 127);
    return 1'b1;
  endfunction

  // queue one sample request; some stretches carry no gaps at all
  function automatic void plan_sample(input sample_t s);
    request_t r;
    r.kind  = KIND_SAMPLE;
    r.value = s;
    r.gap   = ((request_plan.size() % 120) < 24) ? 4'd0 : 4'($urandom_range(0, 15));
    request_plan.push_back(r);
  endfunction

  function automatic void plan_setup(input logic round_bit);
    request_t r;
    r.kind  = KIND_SETUP;
    r.value = sample_t'(round_bit);
    r.gap   = 4'd0;
    request_plan.push_back(r);
  endfunction

  // stimulus, reset and end of run
  initial begin
    shape_t  shape;
    sample_t level;
    sample_t s;
    logic    rail_high;
    int      pulse_at;
    rail_high = 1'b1;
    // directed: truncation, start-up from a cleared line, both rails
    plan_setup(1'b0);
    repeat (DECIM) plan_sample(sample_t'(127));
    repeat (DECIM) plan_sample(sample_t'(-128));
    // random segments, alternating the round setting
    for (int g = 0; g < 4; g++) begin
      plan_setup(~g[0]);
      for (int b = 0; b < ((g == 3) ? 300 : 250) / DECIM; b++) begin
        shape = shape_t'($urandom_range(0, 5));
        level = sample_t'($urandom);
        pulse_at = $urandom_range(0, DECIM - 1);
        if ($urandom_range(0, 3) == 0) begin
          rail_high = ~rail_high;
        end
        for (int k = 0; k < DECIM; k++) begin
          case (shape)
            SHAPE_NOISE: begin
              s = sample_t'($urandom);
            end
            SHAPE_RAIL: begin
              s = rail_high ? sample_t'(127) : sample_t'(-128);
            end
            SHAPE_HELD: begin
              s = level;
            end
            SHAPE_QUIET: begin
              s = sample_t'($urandom_range(0, 7)) - sample_t'(4);
            end
            SHAPE_TOGGLE: begin
              s = k[0] ? sample_t'(127) : sample_t'(-128);
            end
            default: begin
              s = (k == pulse_at) ? (rail_high ? sample_t'(127) : sample_t'(-128)) : '0;
            end
          endcase
          plan_sample(s);
        end
      end
    end
    plan_len = request_plan.size();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (!(items_taken == plan_len && quiet_cnt >= TAIL));
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // request driver for the sample and setting channels
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      cfg_valid  <= 1'b0;
      drv_loaded = 1'b0;
      drv_wait   = 0;
    end else begin
      in_hold  = in_valid && in_stall;
      cfg_hold = cfg_valid && !cfg_ready;
      in_next  = in_hold;
      cfg_next = cfg_hold;
      if (!in_hold && !cfg_hold) begin
        if (!drv_loaded && request_plan.size() != 0) begin
          drv_req    = request_plan.pop_front();
          drv_loaded = 1'b1;
          drv_wait   = int'(drv_req.gap);
        end
        if (drv_loaded) begin
          if (drv_req.kind == KIND_SETUP) begin
            // setting changes only once the filter has drained
            if (quiet_cnt >= SETTLE && !in_valid) begin
              cfg_data   <= drv_req.value[0];
              cfg_next   = 1'b1;
              drv_loaded = 1'b0;
            end
          end else if (drv_wait != 0) begin
            drv_wait--;
          end else begin
            in_sample  <= drv_req.value;
            in_next    = 1'b1;
            drv_loaded = 1'b0;
          end
        end
      end
      in_valid  <= in_next;
      cfg_valid <= cfg_next;
    end
  end

  // result receiver: random stall per result, one long backlog, quiet stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_hold   <= 0;
      rx_taken  <= 0;
    end else if (out_valid && !out_stall) begin
      rx_taken <= rx_taken + 1;
      if (rx_taken == BACKLOG_AT) begin
        out_stall <= 1'b1;
        rx_hold   <= BACKLOG_LEN - 1;
      end else if ((rx_taken % 32) >= 24) begin
        out_stall <= 1'b0;
        rx_hold   <= 0;
      end else begin
        rx_draw = $urandom_range(0, 15);
        out_stall <= (rx_draw != 0);
        rx_hold   <= (rx_draw == 0) ? 0 : rx_draw - 1;
      end
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: check results, predict from accepted requests
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (history[k]) begin
        history[k] = '0;
      end
      phase_cnt = '0;
      round_on  = 1'b1;
      quiet_cnt   <= 0;
      items_taken <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decimated_q.size() == 0) begin
          $error("unexpected result: filtered %0d overflow %0b", out_filtered, out_overflow);
          err_cnt++;
        end else begin
          want = decimated_q.pop_front();
          if (out_filtered !== want.filtered) begin
            $error("filtered: expected %0d, got %0d", want.filtered, out_filtered);
            err_cnt++;
          end
          if (out_overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, out_overflow);
            err_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (decimate_sample(in_sample, want)) begin
          decimated_q.push_back(want);
        end
      end
      if (cfg_valid && cfg_ready) begin
        round_on = cfg_data;
      end
      items_taken <= items_taken + int'(in_valid && !in_stall) + int'(cfg_valid && cfg_ready);
      // cycles since the last transfer with nothing outstanding
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
          || decimated_q.size() != 0) begin
        quiet_cnt <= 0;
      end else if (quiet_cnt < 1000) begin
        quiet_cnt <= quiet_cnt + 1;
      end
    end
  end

  // watchdog on cycles without any accepted request or taken result
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      stuck_cnt <= 0;
    end else if (stuck_cnt >= STUCK_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stuck_cnt <= stuck_cnt + 1;
    end
  end

endmodule

// ----- files.f -----
hdl/fdt_pkg.sv
hdl/fdt_acc_mem.sv
hdl/fdt_seq.sv
hdl/fdt_mac.sv
hdl/fdt_post.sv
hdl/decimating_fir_by_ten_top.sv
dv/tb.sv
